FILE: rtl/core/dsh_pkg.sv
// Package for the diamond-square heightmap block.
// Holds sizes, input kind codes, register indexes and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
package dsh_pkg;
  localparam int MaxGridLog2Def = 8;
  localparam int HeightBitsDef = 32;
  localparam int GridLog2Rst = 8;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_DRAW  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] REG_GRID  = 2'd0;
  localparam logic [1:0] REG_SCALE = 2'd1;
  localparam logic [1:0] REG_RATIO = 2'd2;

  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_READ   = 3'd2;
  localparam logic [2:0] OP_NBR    = 3'd3;
  localparam logic [2:0] OP_WRITE  = 3'd4;
  localparam logic [2:0] OP_ADV    = 3'd5;
  localparam logic [2:0] OP_CORNER = 3'd6;
  localparam logic [2:0] OP_LOAD   = 3'd7;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] sel;
  } dsh_cmd_t;

  typedef struct packed {
    logic generating;
    logic copy_row;
    logic copy_col;
  } dsh_stat_t;
endpackage

FILE: rtl/core/dsh_ctrl.sv
// Controller state machine of the diamond-square heightmap block.
// Sequences memory reads, writes and result hand-off; depends on dsh_pkg.
`timescale 1ns / 1ps
module dsh_ctrl
  import dsh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic       out_valid,
  input  logic       out_stall,
  input  dsh_stat_t  stat,
  output dsh_cmd_t   cmd,
  output logic       load_out
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CRN  = 4'd1;
  localparam logic [3:0] S_RDA  = 4'd2;
  localparam logic [3:0] S_RDB  = 4'd3;
  localparam logic [3:0] S_N0   = 4'd4;
  localparam logic [3:0] S_N1   = 4'd5;
  localparam logic [3:0] S_N2   = 4'd6;
  localparam logic [3:0] S_N3   = 4'd7;
  localparam logic [3:0] S_WAIT = 4'd8;
  localparam logic [3:0] S_MUL  = 4'd9;
  localparam logic [3:0] S_WR   = 4'd10;
  localparam logic [3:0] S_CPR  = 4'd11;
  localparam logic [3:0] S_CPC  = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic [1:0] crn_r, crn_nxt;
  logic       is_read_r, is_read_nxt;
  logic       acc;

  assign in_stall = (state_r != S_IDLE);
  assign acc = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    crn_nxt = crn_r;
    is_read_nxt = is_read_r;
    cmd = '{op: OP_NONE, sel: 2'd0};
    load_out = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_kind)
            KIND_START: begin
              cmd.op = OP_START;
              crn_nxt = 2'd0;
              state_nxt = S_CRN;
            end
            KIND_READ: begin
              cmd.op = OP_READ;
              is_read_nxt = 1'b1;
              state_nxt = S_RDA;
            end
            KIND_DRAW: begin
              if (stat.generating) begin
                cmd.op = OP_LOAD;
                is_read_nxt = 1'b0;
                state_nxt = S_N0;
              end
            end
            default: ;
          endcase
        end
      end
      S_CRN: begin
        cmd = '{op: OP_CORNER, sel: crn_r};
        crn_nxt = crn_r + 2'd1;
        if (crn_r == 2'd3) state_nxt = S_IDLE;
      end
      S_RDA: state_nxt = S_RDB;
      S_RDB: state_nxt = S_OUT;
      S_N0: begin
        cmd = '{op: OP_NBR, sel: 2'd0};
        state_nxt = S_N1;
      end
      S_N1: begin
        cmd = '{op: OP_NBR, sel: 2'd1};
        state_nxt = S_N2;
      end
      S_N2: begin
        cmd = '{op: OP_NBR, sel: 2'd2};
        state_nxt = S_N3;
      end
      S_N3: begin
        cmd = '{op: OP_NBR, sel: 2'd3};
        state_nxt = S_WAIT;
      end
      S_WAIT: state_nxt = S_MUL;
      S_MUL: state_nxt = S_WR;
      S_WR: begin
        cmd = '{op: OP_WRITE, sel: 2'd0};
        state_nxt = S_CPR;
      end
      S_CPR: begin
        if (stat.copy_row) cmd = '{op: OP_WRITE, sel: 2'd1};
        state_nxt = S_CPC;
      end
      S_CPC: begin
        if (stat.copy_col) cmd = '{op: OP_WRITE, sel: 2'd2};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || !out_stall) begin
          load_out = 1'b1;
          if (!is_read_r) cmd.op = OP_ADV;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      crn_r <= 2'd0;
      is_read_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      crn_r <= crn_nxt;
      is_read_r <= is_read_nxt;
    end
  end
endmodule

FILE: rtl/core/dsh_datapath.sv
// Datapath of the diamond-square heightmap block: height memory, traversal
// registers, mean, displacement multiply and saturation; depends on dsh_pkg.
`timescale 1ns / 1ps
module dsh_datapath
  import dsh_pkg::*;
#(
  parameter int MAX_GRID_LOG2 = MaxGridLog2Def,
  parameter int HEIGHT_BITS = HeightBitsDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dsh_cmd_t               cmd,
  input  logic                   load_out,
  output dsh_stat_t              stat,
  input  logic [3:0]             grid_log2,
  input  logic [31:0]            height_scale,
  input  logic [16:0]            ratio,
  input  logic [14:0]            in_random_draw,
  input  logic [MAX_GRID_LOG2:0] in_read_row,
  input  logic [MAX_GRID_LOG2:0] in_read_col,
  output logic [MAX_GRID_LOG2:0] out_row,
  output logic [MAX_GRID_LOG2:0] out_col,
  output logic [31:0]            out_height,
  output logic                   out_finished
);
  localparam int Pitch = (1 << MAX_GRID_LOG2) + 1;
  localparam int Depth = Pitch * Pitch;
  localparam int AddrW = $clog2(Depth);
  localparam int CW = MAX_GRID_LOG2 + 1;
  localparam int HB = HEIGHT_BITS;
  localparam int GlogRst = (GridLog2Rst > MAX_GRID_LOG2) ? MAX_GRID_LOG2 : GridLog2Rst;

  logic signed [HB-1:0] mem [Depth];
  logic signed [HB-1:0] rdata_r;

  logic [3:0]    glog_r, glog_nxt;
  logic [CW-1:0] row_r, row_nxt, col_r, col_nxt, str_r, str_nxt;
  logic          dia_r, dia_nxt, odd_r, odd_nxt, gen_r, gen_nxt;
  logic [31:0]   scale_r, scale_nxt;
  logic [14:0]   draw_r;
  logic [CW-1:0] nr_r, nc_r;
  logic signed [HB+1:0] sum_r;
  logic [1:0]    acc_cnt_r;
  logic          acc_en_r;
  logic signed [48:0] prod_r;
  logic signed [HB-1:0] h_r;
  logic [CW-1:0] orow_r, ocol_r;
  logic signed [HB-1:0] ohgt_r;
  logic              ofin_r;
  logic          neg_r, neg2_r;
  logic [46:0]   z_r, z2_r;
  logic [32:0]   q1_r;
  logic signed [34:0] disp_r;

  logic [CW-1:0] n_cur, n_start, s2;
  logic [CW-1:0] ar, ac;
  logic          we;
  logic [CW-1:0] wr_row, wr_col;
  logic [AddrW-1:0] addr;
  logic [3:0]    glog_cl;
  logic [16:0]   eratio;
  logic [31:0]   sc_src;
  logic [48:0]   sc_prod;
  logic signed [16:0] dterm;
  logic signed [HB+1:0] mean_v;
  logic signed [49:0] num, absnum;
  logic [47:0]   rnd_v;
  logic [47:0]   rem_v;
  logic [32:0]   q_v;
  logic signed [49:0] disp;
  logic signed [50:0] hsum;
  logic signed [HB-1:0] hsat;
  logic [CW:0]   col_adv, row_adv;
  logic [CW-1:0] rr_cl, rc_cl;

  localparam logic signed [50:0] HMax = (51'sd1 <<< (HB - 1)) - 51'sd1;
  localparam logic signed [50:0] HMin = -(51'sd1 <<< (HB - 1));

  assign glog_cl = (grid_log2 < 4'd1) ? 4'd1 :
                   (grid_log2 > 4'(MAX_GRID_LOG2)) ? 4'(MAX_GRID_LOG2) : grid_log2;
  assign n_cur = CW'(1) << glog_r;
  assign n_start = CW'(1) << glog_cl;
  assign s2 = str_r << 1;
  assign eratio = (ratio > 17'd65536) ? 17'd65536 : ratio;
  assign sc_src = (cmd.op == OP_START) ? height_scale : scale_r;
  assign sc_prod = 49'(sc_src) * 49'(eratio);

  assign stat.generating = gen_r;
  assign stat.copy_row = dia_r && (row_r == '0);
  assign stat.copy_col = dia_r && (col_r == '0);

  always_comb begin
    ar = row_r;
    ac = col_r;
    if (!dia_r) begin
      ar = cmd.sel[1] ? row_r + str_r : row_r - str_r;
      ac = cmd.sel[0] ? col_r + str_r : col_r - str_r;
    end else begin
      case (cmd.sel)
        2'd0: begin
          if (row_r == '0) ac = col_r - str_r;
          else if (col_r == '0) ar = row_r - str_r;
          else ar = row_r - str_r;
        end
        2'd1: begin
          if (row_r == '0) ac = col_r + str_r;
          else ar = row_r + str_r;
        end
        2'd2: begin
          if (row_r == '0) ar = n_cur - str_r;
          else if (col_r == '0) ac = str_r;
          else ac = col_r - str_r;
        end
        default: begin
          if (row_r == '0) ar = str_r;
          else if (col_r == '0) ac = n_cur - str_r;
          else ac = col_r + str_r;
        end
      endcase
    end
  end

  assign rr_cl = (in_read_row > n_cur) ? n_cur : in_read_row;
  assign rc_cl = (in_read_col > n_cur) ? n_cur : in_read_col;

  always_comb begin
    we = 1'b0;
    wr_row = row_r;
    wr_col = col_r;
    if (cmd.op == OP_CORNER) begin
      we = 1'b1;
      wr_row = cmd.sel[1] ? n_cur : '0;
      wr_col = cmd.sel[0] ? n_cur : '0;
    end else if (cmd.op == OP_WRITE) begin
      we = 1'b1;
      if (cmd.sel == 2'd1) wr_row = n_cur;
      if (cmd.sel == 2'd2) wr_col = n_cur;
    end
    if (we) addr = AddrW'(wr_row * Pitch + wr_col);
    else if (cmd.op == OP_READ) addr = AddrW'(rr_cl * Pitch + rc_cl);
    else if (cmd.op == OP_NBR) addr = AddrW'(ar * Pitch + ac);
    else addr = AddrW'(nr_r * Pitch + nc_r);
  end

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= (cmd.op == OP_CORNER) ? '0 : h_r;
    rdata_r <= mem[addr];
  end

  // The rounded division by 65534 is a division by 32767 of half the rounded
  // magnitude, done as a sum of shifted copies plus a small final correction.
  assign dterm = signed'({1'b0, draw_r, 1'b0}) - 17'sd32767;
  assign mean_v = sum_r >>> 2;
  assign num = 50'(prod_r);
  assign absnum = num[49] ? -num : num;
  assign rnd_v = 48'(absnum) + 48'd32767;
  assign rem_v = 48'(z2_r) - (48'(q1_r) << 15) + 48'(q1_r);
  assign q_v = q1_r + 33'(rem_v >= 48'd32767) + 33'(rem_v >= 48'd65534)
             + 33'(rem_v >= 48'd98301);
  assign disp = 50'(disp_r);
  assign hsum = 51'(mean_v) + 51'(disp);
  assign hsat = (hsum > HMax) ? HMax[HB-1:0] : (hsum < HMin) ? HMin[HB-1:0] : hsum[HB-1:0];

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) draw_r <= in_random_draw;
    if (cmd.op == OP_READ) begin
      nr_r <= rr_cl;
      nc_r <= rc_cl;
    end
    if (cmd.op == OP_NBR && cmd.sel == 2'd0) acc_cnt_r <= 2'd0;
    else if (acc_en_r) acc_cnt_r <= acc_cnt_r + 2'd1;
    if (acc_en_r) sum_r <= (acc_cnt_r == 2'd0) ? (HB + 2)'(rdata_r) : sum_r + (HB + 2)'(rdata_r);
    prod_r <= 49'(signed'({1'b0, scale_r})) * 49'(dterm);
    neg_r <= num[49];
    z_r <= rnd_v[47:1];
    neg2_r <= neg_r;
    z2_r <= z_r;
    q1_r <= 33'(z_r >> 15) + 33'(z_r >> 30) + 33'(z_r >> 45);
    disp_r <= neg2_r ? -signed'({2'b00, q_v}) : signed'({2'b00, q_v});
    h_r <= hsat;
    if (load_out) begin
      orow_r <= (cmd.op == OP_ADV) ? row_r : nr_r;
      ocol_r <= (cmd.op == OP_ADV) ? col_r : nc_r;
      ohgt_r <= (cmd.op == OP_ADV) ? h_r : rdata_r;
      ofin_r <= (cmd.op == OP_ADV) && dia_r && (row_adv >= (CW + 1)'(n_cur))
                && (col_adv >= (CW + 1)'(n_cur)) && (str_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) acc_en_r <= 1'b0;
    else acc_en_r <= (cmd.op == OP_NBR);
  end

  assign col_adv = (CW + 1)'(col_r) + (CW + 1)'(s2);
  assign row_adv = dia_r ? (CW + 1)'(row_r) + (CW + 1)'(str_r)
                         : (CW + 1)'(row_r) + (CW + 1)'(s2);

  always_comb begin
    glog_nxt = glog_r;
    row_nxt = row_r;
    col_nxt = col_r;
    str_nxt = str_r;
    dia_nxt = dia_r;
    odd_nxt = odd_r;
    gen_nxt = gen_r;
    scale_nxt = scale_r;
    if (cmd.op == OP_START) begin
      glog_nxt = glog_cl;
      str_nxt = n_start >> 1;
      row_nxt = n_start >> 1;
      col_nxt = n_start >> 1;
      scale_nxt = sc_prod[47:16];
      dia_nxt = 1'b0;
      odd_nxt = 1'b0;
      gen_nxt = 1'b1;
    end else if (cmd.op == OP_ADV) begin
      col_nxt = col_adv[CW-1:0];
      if (col_adv >= (CW + 1)'(n_cur)) begin
        if (!dia_r) begin
          col_nxt = str_r;
          row_nxt = row_adv[CW-1:0];
          if (row_adv >= (CW + 1)'(n_cur)) begin
            dia_nxt = 1'b1;
            odd_nxt = 1'b1;
            row_nxt = '0;
            col_nxt = str_r;
          end
        end else begin
          row_nxt = row_adv[CW-1:0];
          if (row_adv >= (CW + 1)'(n_cur)) begin
            scale_nxt = sc_prod[47:16];
            str_nxt = str_r >> 1;
            dia_nxt = 1'b0;
            odd_nxt = 1'b0;
            if (str_r == CW'(1)) begin
              gen_nxt = 1'b0;
              row_nxt = '0;
              col_nxt = '0;
            end else begin
              row_nxt = str_r >> 1;
              col_nxt = str_r >> 1;
            end
          end else begin
            odd_nxt = !odd_r;
            col_nxt = odd_r ? '0 : str_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glog_r <= 4'(GlogRst);
      row_r <= '0;
      col_r <= '0;
      str_r <= '0;
      dia_r <= 1'b0;
      odd_r <= 1'b0;
      gen_r <= 1'b0;
      scale_r <= '0;
    end else begin
      glog_r <= glog_nxt;
      row_r <= row_nxt;
      col_r <= col_nxt;
      str_r <= str_nxt;
      dia_r <= dia_nxt;
      odd_r <= odd_nxt;
      gen_r <= gen_nxt;
      scale_r <= scale_nxt;
    end
  end

  assign out_row = orow_r;
  assign out_col = ocol_r;
  assign out_height = 32'(ohgt_r);
  assign out_finished = ofin_r;
endmodule

FILE: rtl/core/diamond_square_heightmap_top.sv
// Channel   Direction  Contents
// in_*      input      kind, random_draw, read_row, read_col
// out_*     output     row, col, height, finished
// cfg_*     input      grid_log2, height_scale, ratio writes
// A draw transaction is paced by the single-port height memory: four neighbour reads, a
// displacement pipeline that overlaps them, one mean stage and up to three writes.
// Reset is synchronous and active low; the height memory is not cleared.
// A result waits in the output register while out_stall is high.
`timescale 1ns / 1ps
module diamond_square_heightmap_top
  import dsh_pkg::*;
#(
  parameter int MAX_GRID_LOG2 = MaxGridLog2Def,
  parameter int HEIGHT_BITS = HeightBitsDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_kind,
  input  logic [14:0]            in_random_draw,
  input  logic [MAX_GRID_LOG2:0] in_read_row,
  input  logic [MAX_GRID_LOG2:0] in_read_col,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [MAX_GRID_LOG2:0] out_row,
  output logic [MAX_GRID_LOG2:0] out_col,
  output logic [31:0]            out_height,
  output logic                   out_finished
);
  logic [3:0]  grid_r;
  logic [31:0] hscale_r;
  logic [16:0] ratio_r;
  logic        ovalid_r;
  dsh_cmd_t    cmd;
  dsh_stat_t   stat;
  logic        load_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r <= 4'(GridLog2Rst);
      hscale_r <= 32'd65536;
      ratio_r <= 17'd32768;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID: grid_r <= cfg_data[3:0];
        REG_SCALE: hscale_r <= cfg_data;
        REG_RATIO: ratio_r <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (load_out) ovalid_r <= 1'b1;
    else if (!out_stall) ovalid_r <= 1'b0;
  end
  assign out_valid = ovalid_r;

  dsh_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_kind(in_kind), .out_valid(ovalid_r), .out_stall(out_stall),
    .stat(stat), .cmd(cmd), .load_out(load_out)
  );

  dsh_datapath #(.MAX_GRID_LOG2(MAX_GRID_LOG2), .HEIGHT_BITS(HEIGHT_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .load_out(load_out), .stat(stat),
    .grid_log2(grid_r), .height_scale(hscale_r), .ratio(ratio_r),
    .in_random_draw(in_random_draw), .in_read_row(in_read_row),
    .in_read_col(in_read_col), .out_row(out_row), .out_col(out_col),
    .out_height(out_height), .out_finished(out_finished)
  );
endmodule
